// ----- rtl/spv_pkg.sv -----
// Shared types, constants and helper functions for the spectral viscosity
// and projection pipeline. Used by the top level and its port checker.
package spv_pkg;

  localparam int GRID_SIZE = 64;
  localparam int HALF_GRID = GRID_SIZE / 2;
  localparam int BIN_W     = $clog2(GRID_SIZE);
  localparam int K_W       = BIN_W + 1;
  localparam int R_W       = 2 * BIN_W;
  localparam int C_W       = 2 * BIN_W;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 1;
  localparam int P_W       = 2 * CFG_W;
  localparam int A_W       = P_W + R_W;
  localparam int NUM_W     = DATA_W + C_W + 1;
  localparam int MAG_W     = NUM_W - 1;
  localparam int X_W       = 37;
  localparam int Y_W       = 30;
  localparam int F_W       = 31;
  localparam int N_W       = 6;
  localparam int DIV_BITS  = 4;

  localparam int ST_DIV_FIRST = 4;
  localparam int ST_DIV_LAST  = ST_DIV_FIRST + DATA_W / DIV_BITS - 1;
  localparam int ST_EXP_FIRST = 6;
  localparam int ST_EXP_LAST  = 21;
  localparam int ST_SCALE     = 22;
  localparam int ST_MUL       = 23;
  localparam int ST_OUT       = 24;

  localparam logic [CFG_W-1:0] VISCOSITY_RST = 24'd16777;
  localparam logic [CFG_W-1:0] TIME_STEP_RST = 24'd65536;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [13:0] LN2_RECIP = 14'((64'd1 << 45) / 64'd2977044472);
  localparam logic [F_W-1:0] ONE_Q30 = 31'h4000_0000;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [C_W-1:0]    coef_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VISCOSITY = 1'b0,
    REG_TIME_STEP = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [R_W-1:0]    rem;
    logic [DATA_W-1:0] w;
  } div_st_t;

  function automatic logic signed [NUM_W-1:0] comb2(input data_t a, input coef_t ca,
                                                    input data_t b, input coef_t cb);
    logic signed [NUM_W-1:0] ax;
    logic signed [NUM_W-1:0] cax;
    logic signed [NUM_W-1:0] bx;
    logic signed [NUM_W-1:0] cbx;
    ax  = a;
    cax = ca;
    bx  = b;
    cbx = cb;
    return NUM_W'(ax * cax) + NUM_W'(bx * cbx);
  endfunction

  function automatic div_st_t div_steps(input div_st_t st, input logic [R_W-1:0] d);
    div_st_t      o;
    logic [R_W:0] t;
    o = st;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {o.rem, o.w[DATA_W-1]};
      if (t >= {1'b0, d}) begin
        o.rem = R_W'(t - {1'b0, d});
        o.w   = {o.w[DATA_W-2:0], 1'b1};
      end else begin
        o.rem = t[R_W-1:0];
        o.w   = {o.w[DATA_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

endpackage

// ----- rtl/spectral_viscosity_projection_top.sv -----
// Spectral viscosity and projection pipeline, top level.
// Depends on spv_pkg for widths, constants, divider steps and the MAC helper.

// One frequency bin enters per cycle while in_stall is low; the block
// sustains one bin per clock unless out_stall holds it. The pipeline depth
// is set by the eight multiply pairs of the exponential series, which run
// in parallel with a 32-step quotient unit for the division by r. All stages
// advance together: out_stall holds the whole pipeline while out_valid is
// high and shows at in_stall in the same cycle, so nothing is dropped or
// repeated. Configuration writes apply to bins transferred after the write.
module spectral_viscosity_projection_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [spv_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [spv_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [spv_pkg::BIN_W-1:0]            in_bin_col,
  input  logic [spv_pkg::BIN_W-1:0]            in_bin_row,
  input  logic signed [spv_pkg::DATA_W-1:0]    in_u_real,
  input  logic signed [spv_pkg::DATA_W-1:0]    in_u_imag,
  input  logic signed [spv_pkg::DATA_W-1:0]    in_v_real,
  input  logic signed [spv_pkg::DATA_W-1:0]    in_v_imag,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [spv_pkg::DATA_W-1:0]    out_u_real_out,
  output logic signed [spv_pkg::DATA_W-1:0]    out_u_imag_out,
  output logic signed [spv_pkg::DATA_W-1:0]    out_v_real_out,
  output logic signed [spv_pkg::DATA_W-1:0]    out_v_imag_out,
  output logic                                 out_dc_bin,
  output logic                                 out_clipped
);
  import spv_pkg::*;

  logic                  adv;
  logic [ST_OUT:1]       vld_r;
  logic [CFG_W-1:0]      visc_r;
  logic [CFG_W-1:0]      tstep_r;

  // stage 1
  logic signed [K_W-1:0]   kx_c, ky_c;
  logic signed [2*K_W-1:0] kxx_c, kyy_c, kxy_c;
  logic [R_W-1:0]          r_c;
  logic [R_W-1:0]          r_r [1:ST_DIV_LAST-1];
  coef_t                   cxx1_r, cyy1_r, ncxy1_r;
  logic [P_W-1:0]          p1_r;
  logic                    dc_r [1:ST_MUL];
  data_t                   raw_r [1:ST_MUL][4];

  // stage 2
  logic [A_W-1:0]          a2_r;
  logic signed [NUM_W-1:0] num2_r [4];

  // stage 3
  logic [29:0]             nprod_c;
  logic [NUM_W-1:0]        negn_c [4];
  logic [MAG_W-1:0]        mag_c [4];
  logic [X_W-1:0]          x3_r;
  logic                    big_r [3:ST_EXP_LAST];
  logic [N_W-1:0]          n_r [3:ST_EXP_LAST];
  logic                    sgn_r [3:ST_MUL][4];
  div_st_t                 dv_r [3:ST_DIV_LAST][4];
  div_st_t                 dv_nxt [ST_DIV_FIRST:ST_DIV_LAST][4];
  logic [DATA_W-1:0]       q_r [ST_DIV_LAST+1:ST_SCALE][4];

  // stage 4, 5
  logic [37:0]             nl_c;
  logic [37:0]             diff_c;
  logic [32:0]             rem4_r;
  logic [32:0]             rem5_c;
  logic [N_W-1:0]          n5_c;
  logic [Y_W-1:0]          y_r [5:ST_EXP_LAST-1];
  logic [F_W-1:0]          hz_r [5:ST_EXP_LAST];
  logic [F_W-1:0]          hz_nxt [ST_EXP_FIRST:ST_EXP_LAST];

  // stage 22 .. 24
  logic [F_W-1:0]          f_nxt;
  logic [F_W-1:0]          f_r;
  logic [DATA_W+F_W-1:0]   prod_r [4];
  logic [DATA_W:0]         fmag_c [4];
  logic [DATA_W:0]         fneg_c [4];
  data_t                   res_nxt [4];
  logic [3:0]              clip_c;
  data_t                   res_r [4];
  logic                    dc_out_r;
  logic                    clip_out_r;

  assign adv      = !vld_r[ST_OUT] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      visc_r  <= VISCOSITY_RST;
      tstep_r <= TIME_STEP_RST;
    end else begin
      if (adv) begin
        vld_r <= {vld_r[ST_OUT-1:1], in_valid};
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_VISCOSITY: visc_r  <= cfg_wdata;
          REG_TIME_STEP: tstep_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    kx_c = (in_bin_col <= BIN_W'(HALF_GRID)) ? $signed({1'b0, in_bin_col})
                                              : $signed({1'b0, in_bin_col} - K_W'(GRID_SIZE));
    ky_c = (in_bin_row <= BIN_W'(HALF_GRID)) ? $signed({1'b0, in_bin_row})
                                              : $signed({1'b0, in_bin_row} - K_W'(GRID_SIZE));
    kxx_c = kx_c * kx_c;
    kyy_c = ky_c * ky_c;
    kxy_c = kx_c * ky_c;
    r_c   = {1'b0, kxx_c[R_W-2:0]} + {1'b0, kyy_c[R_W-2:0]};
  end

  always_comb begin
    nprod_c = 30'(a2_r[44:29]) * 30'(LN2_RECIP);
    for (int l = 0; l < 4; l++) begin
      negn_c[l] = NUM_W'(0) - NUM_W'(num2_r[l]);
      mag_c[l]  = num2_r[l][NUM_W-1] ? negn_c[l][MAG_W-1:0] : num2_r[l][MAG_W-1:0];
    end
    nl_c   = 38'(n_r[3]) * 38'(LN2_Q32);
    diff_c = {1'b0, x3_r} - nl_c;
    if (rem4_r >= {1'b0, LN2_Q32}) begin
      rem5_c = rem4_r - {1'b0, LN2_Q32};
      n5_c   = n_r[4] + N_W'(1);
    end else begin
      rem5_c = rem4_r;
      n5_c   = n_r[4];
    end
    if (big_r[ST_EXP_LAST] || (n_r[ST_EXP_LAST] > N_W'(30))) begin
      f_nxt = '0;
    end else begin
      f_nxt = hz_r[ST_EXP_LAST] >> n_r[ST_EXP_LAST][4:0];
    end
  end

  for (genvar s = ST_EXP_FIRST; s <= ST_EXP_LAST; s++) begin : g_exp
    if ((s % 2) == 0) begin : g_mul
      logic [60:0] pr;
      assign pr        = 61'(y_r[s-1]) * 61'(hz_r[s-1]);
      assign hz_nxt[s] = {1'b0, pr[59:30]};
    end else begin : g_div
      localparam int          KD = 8 - (s - ST_EXP_FIRST - 1) / 2;
      localparam logic [33:0] RK = 34'(((64'd1 << 33) + KD - 1) / KD);
      logic [63:0] pr;
      assign pr        = 64'(hz_r[s-1][29:0]) * 64'(RK);
      assign hz_nxt[s] = ONE_Q30 - {1'b0, pr[62:33]};
    end
  end

  for (genvar s = ST_DIV_FIRST; s <= ST_DIV_LAST; s++) begin : g_quo
    for (genvar l = 0; l < 4; l++) begin : g_lane
      assign dv_nxt[s][l] = div_steps(dv_r[s-1][l], r_r[s-1]);
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      fmag_c[l] = prod_r[l][DATA_W+F_W-1:30];
      fneg_c[l] = (DATA_W+1)'(0) - fmag_c[l];
      clip_c[l] = 1'b0;
      if (dc_r[ST_MUL]) begin
        res_nxt[l] = raw_r[ST_MUL][l];
      end else if (!sgn_r[ST_MUL][l]) begin
        if (fmag_c[l] > 33'h0_7FFF_FFFF) begin
          res_nxt[l] = 32'sh7FFF_FFFF;
          clip_c[l]  = 1'b1;
        end else begin
          res_nxt[l] = fmag_c[l][DATA_W-1:0];
        end
      end else begin
        if (fmag_c[l] > 33'h0_8000_0000) begin
          res_nxt[l] = 32'sh8000_0000;
          clip_c[l]  = 1'b1;
        end else begin
          res_nxt[l] = fneg_c[l][DATA_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      r_r[1]      <= r_c;
      cxx1_r      <= kxx_c[C_W-1:0];
      cyy1_r      <= kyy_c[C_W-1:0];
      ncxy1_r     <= C_W'(-kxy_c);
      p1_r        <= {24'b0, visc_r} * {24'b0, tstep_r};
      dc_r[1]     <= (r_c == '0);
      raw_r[1][0] <= in_u_real;
      raw_r[1][1] <= in_u_imag;
      raw_r[1][2] <= in_v_real;
      raw_r[1][3] <= in_v_imag;
      for (int s = 2; s <= ST_MUL; s++) begin
        dc_r[s]  <= dc_r[s-1];
        raw_r[s] <= raw_r[s-1];
      end
      for (int s = 2; s < ST_DIV_LAST; s++) begin
        r_r[s] <= r_r[s-1];
      end
      // stage 2
      a2_r      <= {{(A_W-R_W){1'b0}}, r_r[1]} * {{R_W{1'b0}}, p1_r};
      num2_r[0] <= comb2(raw_r[1][0], cyy1_r, raw_r[1][2], ncxy1_r);
      num2_r[1] <= comb2(raw_r[1][1], cyy1_r, raw_r[1][3], ncxy1_r);
      num2_r[2] <= comb2(raw_r[1][0], ncxy1_r, raw_r[1][2], cxx1_r);
      num2_r[3] <= comb2(raw_r[1][1], ncxy1_r, raw_r[1][3], cxx1_r);
      // stage 3
      big_r[3] <= |a2_r[A_W-1:45];
      x3_r     <= a2_r[44:8];
      n_r[3]   <= nprod_c[29:24];
      for (int l = 0; l < 4; l++) begin
        sgn_r[3][l]    <= num2_r[l][NUM_W-1];
        dv_r[3][l].rem <= mag_c[l][MAG_W-1:DATA_W];
        dv_r[3][l].w   <= mag_c[l][DATA_W-1:0];
      end
      for (int s = 4; s <= ST_MUL; s++) begin
        sgn_r[s] <= sgn_r[s-1];
      end
      // stage 4
      rem4_r <= diff_c[32:0];
      n_r[4] <= n_r[3];
      // stage 5
      n_r[5]  <= n5_c;
      y_r[5]  <= rem5_c[31:2];
      hz_r[5] <= ONE_Q30;
      for (int s = 4; s <= ST_EXP_LAST; s++) begin
        big_r[s] <= big_r[s-1];
      end
      for (int s = 6; s <= ST_EXP_LAST; s++) begin
        n_r[s]  <= n_r[s-1];
        hz_r[s] <= hz_nxt[s];
      end
      for (int s = 6; s < ST_EXP_LAST; s++) begin
        y_r[s] <= y_r[s-1];
      end
      // quotient unit
      for (int s = ST_DIV_FIRST; s <= ST_DIV_LAST; s++) begin
        dv_r[s] <= dv_nxt[s];
      end
      for (int l = 0; l < 4; l++) begin
        q_r[ST_DIV_LAST+1][l] <= dv_r[ST_DIV_LAST][l].w;
      end
      for (int s = ST_DIV_LAST + 2; s <= ST_SCALE; s++) begin
        q_r[s] <= q_r[s-1];
      end
      // stage 22 .. 24
      f_r <= f_nxt;
      for (int l = 0; l < 4; l++) begin
        prod_r[l] <= (DATA_W+F_W)'(q_r[ST_SCALE][l]) * (DATA_W+F_W)'(f_r);
        res_r[l]  <= res_nxt[l];
      end
      dc_out_r   <= dc_r[ST_MUL];
      clip_out_r <= |clip_c;
    end
  end

  assign out_valid      = vld_r[ST_OUT];
  assign out_u_real_out = res_r[0];
  assign out_u_imag_out = res_r[1];
  assign out_v_real_out = res_r[2];
  assign out_v_imag_out = res_r[3];
  assign out_dc_bin     = dc_out_r;
  assign out_clipped    = clip_out_r;

endmodule

// ----- rtl/spv_checker.sv -----
// Port-level checker for the spectral viscosity and projection top level.
// Depends on spv_pkg; bound to spectral_viscosity_projection_top below.
module spv_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 cfg_wr_en,
  input logic [spv_pkg::CFG_IDX_W-1:0]        cfg_index,
  input logic [spv_pkg::CFG_W-1:0]            cfg_wdata,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic [spv_pkg::BIN_W-1:0]            in_bin_col,
  input logic [spv_pkg::BIN_W-1:0]            in_bin_row,
  input logic signed [spv_pkg::DATA_W-1:0]    in_u_real,
  input logic signed [spv_pkg::DATA_W-1:0]    in_u_imag,
  input logic signed [spv_pkg::DATA_W-1:0]    in_v_real,
  input logic signed [spv_pkg::DATA_W-1:0]    in_v_imag,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [spv_pkg::DATA_W-1:0]    out_u_real_out,
  input logic signed [spv_pkg::DATA_W-1:0]    out_u_imag_out,
  input logic signed [spv_pkg::DATA_W-1:0]    out_v_real_out,
  input logic signed [spv_pkg::DATA_W-1:0]    out_v_imag_out,
  input logic                                 out_dc_bin,
  input logic                                 out_clipped
);
  import spv_pkg::*;

  localparam data_t MAX_Q = 32'sh7FFF_FFFF;
  localparam data_t MIN_Q = 32'sh8000_0000;

  a_dc_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dc_bin |-> !out_clipped)
    else $error("dc bin reported as clipped");

  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      (out_u_real_out == MAX_Q) || (out_u_real_out == MIN_Q) ||
      (out_u_imag_out == MAX_Q) || (out_u_imag_out == MIN_Q) ||
      (out_v_real_out == MAX_Q) || (out_v_real_out == MIN_Q) ||
      (out_v_imag_out == MAX_Q) || (out_v_imag_out == MIN_Q))
    else $error("clipped set with no component at a rail");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output side can advance");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output valid dropped under stall");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind spectral_viscosity_projection_top spv_checker u_spv_checker (.*);
